[sv/cltp_pkg.sv]
// ---------------------------------------------------------------------------
// Command line token parser: shared package
// Types, constants and keyword tables used by the parser's front end, the
// descriptor queue, the emitter and the top level.
// ---------------------------------------------------------------------------
`default_nettype none

package cltp_pkg;

  // Size limits of the words on one line.
  localparam int unsigned MAX_ARG_LEN    = 16;
  localparam int unsigned FIRST_WORD_CAP = 31;

  // Derived widths.
  localparam int unsigned ARG_IDX_W  = (MAX_ARG_LEN > 1) ? $clog2(MAX_ARG_LEN) : 1;
  localparam int unsigned WLEN_MAX   = (FIRST_WORD_CAP > MAX_ARG_LEN) ?
                                       FIRST_WORD_CAP : MAX_ARG_LEN;
  localparam int unsigned WLEN_W     = $clog2(WLEN_MAX + 1);
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned RAM_ADDR_W = ARG_IDX_W + 2;
  localparam int unsigned RAM_DEPTH  = 2 ** RAM_ADDR_W;

  // Result buffer in the emitter.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  // Character codes.
  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Numeric bounds of the set-param arguments.
  localparam logic [19:0] CTL_BOUND = 20'd65535;
  localparam logic [10:0] VAL_BOUND = 11'd127;

  // Bits of the number error flags.
  localparam logic NUM_ERR_CTL = 1'b0;
  localparam logic NUM_ERR_VAL = 1'b1;

  // Argument store selection inside one bank.
  localparam logic STORE_FIRST  = 1'b0;
  localparam logic STORE_SECOND = 1'b1;

  // Keyword table. Entries 0..4 are the commands, entries 5 and 6 the two
  // port names that may precede a command.
  localparam int unsigned KW_COUNT   = 7;
  localparam int unsigned KW_MAX_LEN = 13;
  localparam int unsigned KW_POS_W   = 4;

  localparam logic [KW_COUNT-1:0] KW_MASK_ALL  = 7'h7F;
  localparam logic [KW_COUNT-1:0] KW_CMD_MASK  = 7'h1F;
  localparam logic [KW_COUNT-1:0] KW_PORT_MASK = 7'h60;

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd4, 4'd8, 4'd9, 4'd10, 4'd13, 4'd11
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{8'h50, 8'h4C, 8'h41, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{8'h4F, 8'h50, 8'h45, 8'h4E, 8'h53, 8'h4F, 8'h4E, 8'h47, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{8'h45, 8'h58, 8'h50, 8'h4F, 8'h52, 8'h54, 8'h57, 8'h41, 8'h56, 8'h00,
      8'h00, 8'h00, 8'h00},
    '{8'h53, 8'h45, 8'h54, 8'h52, 8'h50, 8'h50, 8'h41, 8'h52, 8'h41, 8'h4D,
      8'h00, 8'h00, 8'h00},
    '{8'h52, 8'h45, 8'h49, 8'h4E, 8'h43, 8'h41, 8'h52, 8'h4E, 8'h41, 8'h54,
      8'h49, 8'h4F, 8'h4E},
    '{8'h52, 8'h45, 8'h42, 8'h49, 8'h52, 8'h54, 8'h48, 8'h41, 8'h52, 8'h4F,
      8'h53, 8'h00, 8'h00}
  };

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_ARG1   = 2'd1,
    KIND_ARG2   = 2'd2
  } kind_e;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_PLAY       = 3'd1,
    CMD_STOP       = 3'd2,
    CMD_OPEN_SONG  = 3'd3,
    CMD_EXPORT_WAV = 3'd4,
    CMD_SET_PARAM  = 3'd5
  } cmd_e;

  // Emitter states.
  typedef enum logic [1:0] {
    BK_HDR  = 2'd0,
    BK_ARG1 = 2'd1,
    BK_ARG2 = 2'd2
  } bk_state_e;

  // Input word.
  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } in_item_t;

  // Result word.
  typedef struct packed {
    kind_e            kind;
    logic             status;
    cmd_e             command;
    logic [15:0]      control_number;
    logic [6:0]       param_value;
    logic [LEN_W-1:0] first_arg_length;
    logic [LEN_W-1:0] second_arg_length;
    logic [7:0]       arg_char;
    logic             last_of_run;
  } out_item_t;

  // Finished line, handed from the front end to the emitter.
  typedef struct packed {
    logic             status;
    cmd_e             command;
    logic [15:0]      control_number;
    logic [6:0]       param_value;
    logic [LEN_W-1:0] n1;
    logic [LEN_W-1:0] n2;
    logic             sel1;
  } desc_t;

  // Write request into the argument store.
  typedef struct packed {
    logic                  we;
    logic [RAM_ADDR_W-1:0] addr;
    logic [7:0]            data;
  } ram_wr_t;

endpackage

`default_nettype wire

[sv/cltp_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cltp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/cltp_front.sv]
// ---------------------------------------------------------------------------
// Command line token parser: front end
// Takes one character word per cycle while the line queue has room, splits the
// line into words, matches keywords, accumulates numbers and writes argument
// characters into the store; the end word pushes a finished line descriptor.
// ---------------------------------------------------------------------------
`default_nettype none

module cltp_front import cltp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_i,
  input  logic     queue_full_i,
  input  logic     wbank_i,
  output logic     desc_push_o,
  output desc_t    desc_o,
  output ram_wr_t  ram_wr_o
);

  // Per-line state.
  logic [1:0]          wi_q, wi_d;
  logic [WLEN_W-1:0]   wlen_q, wlen_d;
  logic                port_q, port_d;
  logic [KW_COUNT-1:0] mask_q, mask_d;
  logic                line_err_q, line_err_d;
  logic [LEN_W-1:0]    n1_q, n1_d;
  logic [LEN_W-1:0]    n2_q, n2_d;
  logic [15:0]         ctl_q, ctl_d;
  logic [6:0]          val_q, val_d;
  logic [1:0]          num_err_q, num_err_d;

  logic accept;
  logic matching;

  // State after closing the current word.
  logic [KW_COUNT-1:0] exact;
  logic [1:0]          fin_wi;
  logic                fin_port;
  logic [KW_COUNT-1:0] fin_mask;
  logic [LEN_W-1:0]    fin_n1;
  logic [LEN_W-1:0]    fin_n2;

  // Character handling.
  logic [WLEN_W-1:0]   cap;
  logic                take_err;
  logic [KW_COUNT-1:0] tk_mask;
  logic                is_digit;
  logic [3:0]          digit;
  logic [19:0]         ctl_t;
  logic [10:0]         val_t;
  logic                nbit;

  // Line check.
  logic       err;
  logic [1:0] nw;
  logic [1:0] need;
  cmd_e       cmd;

  assign accept   = push_i && !queue_full_i;
  assign matching = (wi_q == 2'd0) || ((wi_q == 2'd1) && port_q);

  // Effect of closing the current word.
  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      exact[k] = (WLEN_W'(KW_LEN[k]) == wlen_q);
    end
    exact    = exact & mask_q;
    fin_wi   = wi_q;
    fin_port = port_q;
    fin_mask = mask_q;
    fin_n1   = n1_q;
    fin_n2   = n2_q;
    if (wlen_q != '0) begin
      if (matching) begin
        if ((wi_q == 2'd0) && ((exact & KW_PORT_MASK) != '0)) begin
          fin_port = 1'b1;
          fin_mask = KW_MASK_ALL;
        end else begin
          fin_mask = exact & KW_CMD_MASK;
        end
      end
      if (wi_q == 2'd1) begin
        fin_n1 = LEN_W'(wlen_q);
      end else if (wi_q == 2'd2) begin
        fin_n2 = LEN_W'(wlen_q);
      end
      if (wi_q != 2'd3) begin
        fin_wi = wi_q + 2'd1;
      end
    end
  end

  // Keyword narrowing and number accumulation for one character.
  always_comb begin
    cap      = (wi_q == 2'd0) ? WLEN_W'(FIRST_WORD_CAP) : WLEN_W'(MAX_ARG_LEN);
    take_err = (wi_q == 2'd3) || (wlen_q >= cap);
    tk_mask  = mask_q;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((wlen_q >= WLEN_W'(KW_LEN[k])) ||
          (KW_TEXT[k][wlen_q[KW_POS_W-1:0]] != in_i.ch)) begin
        tk_mask[k] = 1'b0;
      end
    end
    is_digit = (in_i.ch >= CHAR_ZERO) && (in_i.ch <= CHAR_NINE);
    digit    = 4'(in_i.ch - CHAR_ZERO);
    ctl_t    = (20'(ctl_q) << 3) + (20'(ctl_q) << 1) + 20'(digit);
    val_t    = (11'(val_q) << 3) + (11'(val_q) << 1) + 11'(digit);
    nbit     = (wi_q == 2'd2) ? NUM_ERR_VAL : NUM_ERR_CTL;
  end

  // Next-state logic of the per-line state and store writes.
  always_comb begin
    wi_d          = wi_q;
    wlen_d        = wlen_q;
    port_d        = port_q;
    mask_d        = mask_q;
    line_err_d    = line_err_q;
    n1_d          = n1_q;
    n2_d          = n2_q;
    ctl_d         = ctl_q;
    val_d         = val_q;
    num_err_d     = num_err_q;
    desc_push_o   = 1'b0;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = {wbank_i, (wi_q == 2'd2) ? STORE_SECOND : STORE_FIRST,
                     wlen_q[ARG_IDX_W-1:0]};
    ram_wr_o.data = in_i.ch;
    if (accept) begin
      if (in_i.end_of_line) begin
        desc_push_o = 1'b1;
        wi_d        = '0;
        wlen_d      = '0;
        port_d      = 1'b0;
        mask_d      = KW_MASK_ALL;
        line_err_d  = 1'b0;
        n1_d        = '0;
        n2_d        = '0;
        ctl_d       = '0;
        val_d       = '0;
        num_err_d   = '0;
      end else if (!line_err_q && (in_i.ch != CHAR_NUL)) begin
        if (in_i.ch == CHAR_SPACE) begin
          if (wlen_q == '0) begin
            line_err_d = 1'b1;
          end else begin
            wi_d   = fin_wi;
            port_d = fin_port;
            mask_d = fin_mask;
            n1_d   = fin_n1;
            n2_d   = fin_n2;
            wlen_d = '0;
          end
        end else if (take_err) begin
          line_err_d = 1'b1;
        end else begin
          if (matching) begin
            mask_d = tk_mask;
          end
          if ((wi_q == 2'd1) || (wi_q == 2'd2)) begin
            ram_wr_o.we = 1'b1;
            if (!num_err_q[nbit]) begin
              if (!is_digit) begin
                num_err_d[nbit] = 1'b1;
              end else if (wi_q == 2'd1) begin
                if (ctl_t > CTL_BOUND) begin
                  num_err_d[nbit] = 1'b1;
                end else begin
                  ctl_d = ctl_t[15:0];
                end
              end else begin
                if (val_t > VAL_BOUND) begin
                  num_err_d[nbit] = 1'b1;
                end else begin
                  val_d = val_t[6:0];
                end
              end
            end
          end
          wlen_d = wlen_q + WLEN_W'(1);
        end
      end
    end
  end

  // Line check and descriptor for the end word.
  always_comb begin
    err  = line_err_q || (fin_wi == 2'd0);
    nw   = fin_wi;
    if (fin_port) begin
      if (nw < 2'd2) begin
        err = 1'b1;
      end else begin
        nw = nw - 2'd1;
      end
    end
    if (fin_mask[0]) begin
      cmd = CMD_PLAY;
    end else if (fin_mask[1]) begin
      cmd = CMD_STOP;
    end else if (fin_mask[2]) begin
      cmd = CMD_OPEN_SONG;
    end else if (fin_mask[3]) begin
      cmd = CMD_EXPORT_WAV;
    end else if (fin_mask[4]) begin
      cmd = CMD_SET_PARAM;
    end else begin
      cmd = CMD_NONE;
    end
    if ((cmd == CMD_NONE) || (fin_mask == KW_MASK_ALL)) begin
      err = 1'b1;
    end
    case (cmd)
      CMD_PLAY, CMD_STOP: need = 2'd1;
      CMD_OPEN_SONG:      need = 2'd2;
      default:            need = 2'd3;
    endcase
    if (nw != need) begin
      err = 1'b1;
    end
    desc_o = '0;
    if (!err) begin
      case (cmd)
        CMD_OPEN_SONG: begin
          desc_o.sel1 = fin_port ? STORE_SECOND : STORE_FIRST;
          desc_o.n1   = fin_port ? fin_n2 : fin_n1;
        end
        CMD_EXPORT_WAV: begin
          desc_o.n1 = fin_n1;
          desc_o.n2 = fin_n2;
        end
        CMD_SET_PARAM: begin
          if (num_err_q != '0) begin
            err = 1'b1;
          end
          desc_o.control_number = ctl_q;
          desc_o.param_value    = val_q;
        end
        default: begin
        end
      endcase
    end
    if (err) begin
      desc_o        = '0;
      desc_o.status = 1'b1;
    end else begin
      desc_o.command = cmd;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q       <= '0;
      wlen_q     <= '0;
      port_q     <= 1'b0;
      mask_q     <= KW_MASK_ALL;
      line_err_q <= 1'b0;
      n1_q       <= '0;
      n2_q       <= '0;
      ctl_q      <= '0;
      val_q      <= '0;
      num_err_q  <= '0;
    end else begin
      wi_q       <= wi_d;
      wlen_q     <= wlen_d;
      port_q     <= port_d;
      mask_q     <= mask_d;
      line_err_q <= line_err_d;
      n1_q       <= n1_d;
      n2_q       <= n2_d;
      ctl_q      <= ctl_d;
      val_q      <= val_d;
      num_err_q  <= num_err_d;
    end
  end

endmodule

`default_nettype wire

[sv/cltp_desc_queue.sv]
// ---------------------------------------------------------------------------
// Command line token parser: line descriptor queue
// Two-entry queue of finished lines. The entry position also names the bank
// of the argument store that holds the line's characters.
// ---------------------------------------------------------------------------
`default_nettype none

module cltp_desc_queue import cltp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t desc_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  empty_o,
  output desc_t head_o,
  output logic  wbank_o,
  output logic  rbank_o
);

  desc_t      entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = entry_q[rptr_q];
  assign wbank_o = wptr_q;
  assign rbank_o = rptr_q;

  // Pointer and count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= desc_i;
    end
  end

  // A push never lands on a full queue, since the front end stalls then.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("descriptor pushed into a full queue");

endmodule

`default_nettype wire

[sv/cltp_back.sv]
// ---------------------------------------------------------------------------
// Command line token parser: result emitter
// Walks the head line descriptor, issues the header and the argument
// character reads, and buffers results in a small queue toward the output.
// ---------------------------------------------------------------------------
`default_nettype none

module cltp_back import cltp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  desc_empty_i,
  input  desc_t                 desc_i,
  input  logic                  rbank_i,
  output logic                  desc_pop_o,
  output logic                  ram_re_o,
  output logic [RAM_ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]            ram_rdata_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_o
);

  bk_state_e            state_q, state_d;
  logic [ARG_IDX_W-1:0] idx_q, idx_d;

  logic      issue;
  out_item_t iss_item;
  logic      iss_is_char;
  logic      char_last1;
  logic      char_last2;

  // Read pipeline stage, one result in flight.
  logic      s1_valid_q;
  out_item_t s1_item_q;
  logic      s1_is_char_q;
  out_item_t s1_out;

  // Result queue.
  out_item_t            fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] fwptr_q, frptr_q;
  logic [OUT_CNT_W-1:0] fcnt_q, fcnt_d;
  logic                 fpop;

  assign issue = !desc_empty_i &&
                 ((fcnt_q + OUT_CNT_W'(s1_valid_q)) < OUT_CNT_W'(OUT_DEPTH));

  assign char_last1 = ((6'(idx_q) + 6'd1) == 6'(desc_i.n1));
  assign char_last2 = ((6'(idx_q) + 6'd1) == 6'(desc_i.n2));

  // Sequencer over the results of the head line.
  always_comb begin
    state_d              = state_q;
    idx_d                = idx_q;
    desc_pop_o           = 1'b0;
    ram_re_o             = 1'b0;
    ram_raddr_o          = {rbank_i, STORE_SECOND, idx_q};
    iss_is_char          = 1'b0;
    iss_item             = '0;
    iss_item.kind        = KIND_HEADER;
    unique case (state_q)
      BK_HDR: begin
        iss_item.status            = desc_i.status;
        iss_item.command           = desc_i.command;
        iss_item.control_number    = desc_i.control_number;
        iss_item.param_value       = desc_i.param_value;
        iss_item.first_arg_length  = desc_i.n1;
        iss_item.second_arg_length = desc_i.n2;
        iss_item.last_of_run       = (desc_i.n1 == '0) && (desc_i.n2 == '0);
        if (issue) begin
          idx_d = '0;
          if (iss_item.last_of_run) begin
            desc_pop_o = 1'b1;
          end else if (desc_i.n1 != '0) begin
            state_d = BK_ARG1;
          end else begin
            state_d = BK_ARG2;
          end
        end
      end
      BK_ARG1: begin
        iss_item.kind        = KIND_ARG1;
        iss_item.last_of_run = char_last1 && (desc_i.n2 == '0);
        iss_is_char          = 1'b1;
        ram_raddr_o          = {rbank_i, desc_i.sel1, idx_q};
        if (issue) begin
          ram_re_o = 1'b1;
          if (char_last1) begin
            idx_d = '0;
            if (desc_i.n2 != '0) begin
              state_d = BK_ARG2;
            end else begin
              state_d    = BK_HDR;
              desc_pop_o = 1'b1;
            end
          end else begin
            idx_d = idx_q + ARG_IDX_W'(1);
          end
        end
      end
      BK_ARG2: begin
        iss_item.kind        = KIND_ARG2;
        iss_item.last_of_run = char_last2;
        iss_is_char          = 1'b1;
        if (issue) begin
          ram_re_o = 1'b1;
          if (char_last2) begin
            idx_d      = '0;
            state_d    = BK_HDR;
            desc_pop_o = 1'b1;
          end else begin
            idx_d = idx_q + ARG_IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = BK_HDR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_HDR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // Stage that waits for the registered store read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_item_q    <= iss_item;
      s1_is_char_q <= iss_is_char;
    end
  end

  always_comb begin
    s1_out          = s1_item_q;
    s1_out.arg_char = s1_is_char_q ? ram_rdata_i : 8'd0;
  end

  // Result queue toward the output ports.
  assign fpop  = pop && (fcnt_q != '0);
  assign empty = (fcnt_q == '0);
  assign out_o = fifo_q[frptr_q];

  always_comb begin
    fcnt_d = fcnt_q + OUT_CNT_W'(s1_valid_q) - OUT_CNT_W'(fpop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwptr_q <= '0;
      frptr_q <= '0;
      fcnt_q  <= '0;
    end else begin
      fcnt_q <= fcnt_d;
      if (s1_valid_q) begin
        fwptr_q <= fwptr_q + OUT_PTR_W'(1);
      end
      if (fpop) begin
        frptr_q <= frptr_q + OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[fwptr_q] <= s1_out;
    end
  end

  // The head descriptor is retired only while one is present.
  a_pop_needs_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    desc_pop_o |-> !desc_empty_i)
    else $error("descriptor retired from an empty queue");

  // A result coming out of the read stage always finds room.
  a_room_for_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (fcnt_q < OUT_CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");

  // Character results are only issued while a line is at the head.
  a_read_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re_o |-> (!desc_empty_i && (state_q != BK_HDR)))
    else $error("argument read without a line");

endmodule

`default_nettype wire

[sv/command_line_token_parser_core.sv]
// ---------------------------------------------------------------------------
// Command line token parser
// Splits a text line into words, recognizes the command and its arguments,
// and returns a header word followed by the argument characters.
// ---------------------------------------------------------------------------
// The block takes one input word per clock cycle while full is low, characters
// and end words alike, and gives at most one result word per cycle. A line
// closed by an end word produces 1 + n1 + n2 results (header, then first and
// second argument characters). The header reaches the result ports through
// the line queue, the read stage and the result queue.
// Argument characters sit in a store of two banks, one per finished line, so
// the input side keeps taking characters while an earlier line is still being
// emitted; full rises only while two finished lines wait on the result side.
// ---------------------------------------------------------------------------
`default_nettype none

module command_line_token_parser_core import cltp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_data_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_data_o
);

  logic                  desc_push;
  desc_t                 desc_in;
  logic                  desc_pop;
  logic                  desc_full;
  logic                  desc_empty;
  desc_t                 desc_head;
  logic                  wbank;
  logic                  rbank;
  ram_wr_t               ram_wr;
  logic                  ram_re;
  logic [RAM_ADDR_W-1:0] ram_raddr;
  logic [7:0]            ram_rdata;

  assign full = desc_full;

  // Word splitting and classification.
  cltp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .in_i         (in_data_i),
    .queue_full_i (desc_full),
    .wbank_i      (wbank),
    .desc_push_o  (desc_push),
    .desc_o       (desc_in),
    .ram_wr_o     (ram_wr)
  );

  // Finished lines between the two halves.
  cltp_desc_queue u_desc_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (desc_push),
    .desc_i  (desc_in),
    .pop_i   (desc_pop),
    .full_o  (desc_full),
    .empty_o (desc_empty),
    .head_o  (desc_head),
    .wbank_o (wbank),
    .rbank_o (rbank)
  );

  // Argument character store, two banks of two arguments.
  cltp_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_arg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.we),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result emission.
  cltp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_empty_i (desc_empty),
    .desc_i       (desc_head),
    .rbank_i      (rbank),
    .desc_pop_o   (desc_pop),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .empty        (empty),
    .pop          (pop),
    .out_o        (out_data_o)
  );

endmodule

`default_nettype wire

[verif/cltp_result_checker.sv]
// ---------------------------------------------------------------------------
// Command line parser result checker
// Watches both queue ports of the parser. Every accepted input word is run
// through a line parser kept here, which queues the result words the line
// should produce; every popped result word is compared with the oldest one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cltp_result_checker import cltp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  in_item_t    in_data_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  out_item_t   out_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned accepted_lines_o,
  output int unsigned rejected_lines_o
);

  localparam int unsigned ARG_CHARS_MAX  = 16;
  localparam int unsigned FIRST_WORD_MAX = 31;
  localparam int unsigned CONTROL_LIMIT  = 65535;
  localparam int unsigned VALUE_LIMIT    = 127;
  localparam logic [7:0]  SPACE_CHAR     = 8'd32;

  // Per-line parse state.
  logic [1:0]       word_idx;
  logic [5:0]       word_len;
  logic             port_seen;
  logic [6:0]       kw_mask;
  logic             line_err;
  logic [7:0]       first_store [ARG_CHARS_MAX];
  logic [7:0]       second_store [ARG_CHARS_MAX];
  logic [LEN_W-1:0] first_len;
  logic [LEN_W-1:0] second_len;
  int unsigned      control_acc;
  int unsigned      value_acc;
  logic [1:0]       num_err;

  // Result words still owed by the parser, oldest first.
  out_item_t parsed_words_q [$];
  out_item_t want;

  // Keywords: five commands, then the two port names.
  function automatic string kw_text(input int unsigned k);
    case (k)
      0: return "PLAY";
      1: return "STOP";
      2: return "OPENSONG";
      3: return "EXPORTWAV";
      4: return "SETRPPARAM";
      5: return {"RE", "INCARNATION"};
      default: return {"REBIRTH", "AROS"};
    endcase
  endfunction

  // The command word is the first word, or the second one after a port name.
  function automatic bit keyword_slot();
    return word_idx == 2'd0 || (word_idx == 2'd1 && port_seen);
  endfunction

  task automatic clear_line_state();
    word_idx    = '0;
    word_len    = '0;
    port_seen   = 1'b0;
    kw_mask     = '1;
    line_err    = 1'b0;
    first_len   = '0;
    second_len  = '0;
    control_acc = 0;
    value_acc   = 0;
    num_err     = '0;
  endtask

  // A space or the end of the line closes the current word.
  task automatic close_word();
    logic [6:0] exact;
    if (word_len == 0) return;
    if (keyword_slot()) begin
      exact = '0;
      for (int k = 0; k < 7; k++) begin
        if (kw_text(k).len() == word_len) exact[k] = 1'b1;
      end
      exact &= kw_mask;
      if (word_idx == 2'd0 && exact[6:5] != 2'b00) begin
        port_seen = 1'b1;
        kw_mask   = '1;
      end else begin
        kw_mask = {2'b00, exact[4:0]};
      end
    end
    if (word_idx == 2'd1) first_len = word_len[LEN_W-1:0];
    else if (word_idx == 2'd2) second_len = word_len[LEN_W-1:0];
    if (word_idx < 2'd3) word_idx++;
    word_len = '0;
  endtask

  // One character joins the current word.
  task automatic add_letter(input logic [7:0] c);
    int unsigned cap;
    int unsigned bound;
    int unsigned acc;
    logic        slot;
    string       s;
    if (word_idx == 2'd3) begin
      line_err = 1'b1;
      return;
    end
    cap = (word_idx == 2'd0) ? FIRST_WORD_MAX : ARG_CHARS_MAX;
    if (word_len >= cap) begin
      line_err = 1'b1;
      return;
    end
    if (keyword_slot()) begin
      for (int k = 0; k < 7; k++) begin
        s = kw_text(k);
        if (word_len >= s.len() || s.getc(word_len) != c) kw_mask[k] = 1'b0;
      end
    end
    // Second and third words are kept raw and also read as decimal numbers.
    if (word_idx == 2'd1 || word_idx == 2'd2) begin
      slot  = (word_idx == 2'd2);
      bound = slot ? VALUE_LIMIT : CONTROL_LIMIT;
      acc   = slot ? value_acc : control_acc;
      if (slot) second_store[word_len[3:0]] = c;
      else first_store[word_len[3:0]] = c;
      if (!num_err[slot]) begin
        if (c >= "0" && c <= "9") begin
          acc = acc * 10 + (c - "0");
          if (acc > bound) num_err[slot] = 1'b1;
          else if (slot) value_acc = acc;
          else control_acc = acc;
        end else begin
          num_err[slot] = 1'b1;
        end
      end
    end
    word_len++;
  endtask

  // End of line: judge the line and queue its header and argument characters.
  task automatic close_line();
    logic             bad;
    logic             use_second;
    int unsigned      words;
    int unsigned      need;
    int unsigned      ctl;
    int unsigned      val;
    logic [LEN_W-1:0] n1;
    logic [LEN_W-1:0] n2;
    cmd_e             cmd;
    out_item_t        w;
    if (!line_err) close_word();
    bad   = line_err || word_idx == 2'd0;
    words = word_idx;
    if (port_seen) begin
      if (words < 2) bad = 1'b1;
      else words--;
    end
    cmd = CMD_NONE;
    for (int b = 4; b >= 0; b--) begin
      if (kw_mask[b]) cmd = cmd_e'(b + 1);
    end
    if (cmd == CMD_NONE || kw_mask == '1) bad = 1'b1;
    case (cmd)
      CMD_PLAY, CMD_STOP: need = 1;
      CMD_OPEN_SONG:      need = 2;
      default:            need = 3;
    endcase
    if (!bad && words != need) bad = 1'b1;
    n1 = '0;
    n2 = '0;
    ctl = 0;
    val = 0;
    use_second = 1'b0;
    if (!bad) begin
      case (cmd)
        CMD_OPEN_SONG: begin
          if (port_seen) begin
            use_second = 1'b1;
            n1 = second_len;
          end else begin
            n1 = first_len;
          end
        end
        CMD_EXPORT_WAV: begin
          n1 = first_len;
          n2 = second_len;
        end
        CMD_SET_PARAM: begin
          if (num_err != 2'b00) bad = 1'b1;
          ctl = control_acc;
          val = value_acc;
        end
        default: ;
      endcase
    end
    w = '0;
    if (bad) begin
      w.kind        = KIND_HEADER;
      w.status      = 1'b1;
      w.last_of_run = 1'b1;
      parsed_words_q.push_back(w);
      rejected_lines_o++;
    end else begin
      w.kind              = KIND_HEADER;
      w.command           = cmd;
      w.control_number    = ctl[15:0];
      w.param_value       = val[6:0];
      w.first_arg_length  = n1;
      w.second_arg_length = n2;
      w.last_of_run       = (n1 == 0 && n2 == 0);
      parsed_words_q.push_back(w);
      for (int i = 0; i < n1; i++) begin
        w = '0;
        w.kind        = KIND_ARG1;
        w.arg_char    = use_second ? second_store[i] : first_store[i];
        w.last_of_run = (i + 1 == n1 && n2 == 0);
        parsed_words_q.push_back(w);
      end
      for (int i = 0; i < n2; i++) begin
        w = '0;
        w.kind        = KIND_ARG2;
        w.arg_char    = second_store[i];
        w.last_of_run = (i + 1 == n2);
        parsed_words_q.push_back(w);
      end
      accepted_lines_o++;
    end
    clear_line_state();
  endtask

  task automatic parse_input_word(input in_item_t it);
    if (it.end_of_line) begin
      close_line();
    end else if (!line_err && it.ch != 8'd0) begin
      if (it.ch != SPACE_CHAR) add_letter(it.ch);
      else if (word_len == 0) line_err = 1'b1;
      else close_word();
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      fail_count_o++;
      $display("%0t: %s differs, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
    end
  endtask

  // Both ports are sampled at the rising edge; the input side goes first.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_line_state();
      parsed_words_q.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      checked_o        = 0;
      accepted_lines_o = 0;
      rejected_lines_o = 0;
    end else begin
      if (push_i && !full_i) parse_input_word(in_data_i);
      if (pop_i && !empty_i) begin
        if (parsed_words_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result word %h arrived, expected nothing", $time, out_data_i);
        end else begin
          want = parsed_words_q.pop_front();
          check_field("kind", want.kind, out_data_i.kind);
          check_field("status", want.status, out_data_i.status);
          check_field("command", want.command, out_data_i.command);
          check_field("control_number", want.control_number, out_data_i.control_number);
          check_field("param_value", want.param_value, out_data_i.param_value);
          check_field("first_arg_length", want.first_arg_length,
                      out_data_i.first_arg_length);
          check_field("second_arg_length", want.second_arg_length,
                      out_data_i.second_arg_length);
          check_field("arg_char", want.arg_char, out_data_i.arg_char);
          check_field("last_of_run", want.last_of_run, out_data_i.last_of_run);
          checked_o++;
        end
      end
      pending_o = parsed_words_q.size();
    end
  end

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// Command line parser testbench
// Feeds the parser a few directed lines, then random lines, mostly well
// formed, under changing idle and stall patterns, and ends with one long
// result-side hold that fills the parser and stalls its input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import cltp_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_LINES = 1;
  localparam logic [7:0]  SPACE_CHAR  = 8'd32;

  logic      clk;
  logic      rst_n;
  logic      push;
  logic      full;
  in_item_t  in_data;
  logic      empty;
  logic      pop;
  out_item_t out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned accepted_lines;
  int unsigned rejected_lines;

  int unsigned send_idle_pct;
  int unsigned pop_stall_pct;
  logic        hold_req;
  int unsigned lines_sent;
  int unsigned words_sent;
  logic [7:0]  line_buf [$];

  command_line_token_parser_core u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  cltp_result_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .in_data_i        (in_data),
    .empty_i          (empty),
    .pop_i            (pop),
    .out_data_i       (out_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .accepted_lines_o (accepted_lines),
    .rejected_lines_o (rejected_lines)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Keywords: five commands, then the two port names.
  function automatic string keyword(input int unsigned k);
    case (k)
      0: return "PLAY";
      1: return "STOP";
      2: return "OPENSONG";
      3: return "EXPORTWAV";
      4: return "SETRPPARAM";
      5: return {"RE", "INCARNATION"};
      default: return {"REBIRTH", "AROS"};
    endcase
  endfunction

  // Offers one word after a random idle gap; returns at the falling edge
  // after the word was taken, with push still high.
  task automatic send_word(input in_item_t it);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic flush_line();
    in_item_t it;
    foreach (line_buf[i]) begin
      it.ch          = line_buf[i];
      it.end_of_line = 1'b0;
      send_word(it);
    end
    it.ch          = 8'($urandom_range(255));
    it.end_of_line = 1'b1;
    send_word(it);
    line_buf.delete();
    lines_sent++;
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s.getc(i));
  endtask

  task automatic send_text(input string s);
    put_text(s);
    flush_line();
  endtask

  // A word of n random non-space characters, now and then with a zero byte.
  task automatic put_arg_chars(input int unsigned n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom_range(1, 255)); while (c == SPACE_CHAR);
      if ($urandom_range(19) == 0) line_buf.push_back(8'd0);
      line_buf.push_back(c);
    end
  endtask

  // A decimal field around its bound, sometimes spoiled or oversized.
  task automatic put_number(input int unsigned bound);
    int unsigned v;
    int unsigned n;
    logic [7:0]  c;
    case ($urandom_range(9))
      0: v = bound + 1 + $urandom_range(bound);
      1: v = bound;
      2: v = 0;
      default: v = $urandom_range(bound);
    endcase
    if ($urandom_range(7) == 0) line_buf.push_back("0");
    put_text($sformatf("%0d", v));
    n = $urandom_range(11);
    if (n == 0) begin
      do c = 8'($urandom_range(1, 255));
      while (c == SPACE_CHAR || (c >= "0" && c <= "9"));
      line_buf.push_back(c);
    end else if (n == 1) begin
      repeat ($urandom_range(1, 9)) line_buf.push_back("9");
    end
  endtask

  // Random lines: about three in four are command lines with random
  // arguments, the rest is noise.
  task automatic send_random_lines(input int unsigned count);
    int unsigned k;
    int unsigned words;
    string       s;
    repeat (count) begin
      if ($urandom_range(99) < 75) begin
        k = $urandom_range(4);
        if ($urandom_range(3) == 0) put_text({keyword(5 + $urandom_range(1)), " "});
        put_text(keyword(k));
        if (k == 2 || k == 3) begin
          line_buf.push_back(SPACE_CHAR);
          put_arg_chars($urandom_range(1, 16));
        end
        if (k == 3) begin
          line_buf.push_back(SPACE_CHAR);
          put_arg_chars($urandom_range(1, 16));
        end
        if (k == 4) begin
          line_buf.push_back(SPACE_CHAR);
          put_number(65535);
          line_buf.push_back(SPACE_CHAR);
          put_number(127);
        end
        if ($urandom_range(11) == 0) begin
          line_buf.push_back(SPACE_CHAR);
          put_arg_chars($urandom_range(1, 4));
        end
        if ($urandom_range(7) == 0) line_buf.push_back(SPACE_CHAR);
      end else if ($urandom_range(2) == 0) begin
        // Raw bytes, spaces and zeros included.
        repeat ($urandom_range(24)) begin
          if ($urandom_range(3) == 0) line_buf.push_back(SPACE_CHAR);
          else line_buf.push_back(8'($urandom_range(255)));
        end
      end else begin
        // Word-shaped noise built from mangled keywords and random words.
        if ($urandom_range(5) == 0) line_buf.push_back(SPACE_CHAR);
        words = $urandom_range(5);
        for (int i = 0; i < words; i++) begin
          if (i > 0) begin
            line_buf.push_back(SPACE_CHAR);
            if ($urandom_range(7) == 0) line_buf.push_back(SPACE_CHAR);
          end
          if (i <= 1 && $urandom_range(1) == 0) begin
            s = keyword($urandom_range(6));
            case ($urandom_range(4))
              0: s = s.substr(0, s.len() - 2);
              1: s = {s, "S"};
              2: s = s.tolower();
              3: begin
                k = $urandom_range(s.len() - 1);
                s.putc(k, s.getc(k) ^ 8'h01);
              end
              default: ;
            endcase
            put_text(s);
          end else begin
            put_arg_chars($urandom_range(1, ($urandom_range(4) == 0) ? 40 : 6));
          end
        end
        if ($urandom_range(3) == 0) line_buf.push_back(SPACE_CHAR);
      end
      flush_line();
    end
  endtask

  // Result side: random stalls, plus one long hold counted here.
  initial begin
    int unsigned hold_cnt;
    hold_cnt = 0;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        pop <= 1'b0;
        hold_cnt++;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    push          = 1'b0;
    in_data       = '0;
    rst_n         = 1'b0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_req      = 1'b0;
    lines_sent    = 0;
    words_sent    = 0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed lines: a plain command, a port name ahead of a song name,
    // numeric extremes and a leading space.
    send_text("PLAY");
    put_text({keyword(6), " OPENSONG "});
    line_buf.push_back(8'hFF);
    line_buf.push_back(8'h01);
    flush_line();
    send_text("SETRPPARAM 65535 127");
    send_text(" PLAY");

    // Random lines under four idle patterns.
    send_random_lines(PHASE_LINES);
    send_idle_pct = 59;
    send_random_lines(PHASE_LINES);
    send_idle_pct = 0;
    pop_stall_pct = 59;
    send_random_lines(PHASE_LINES);
    send_idle_pct = 24;
    pop_stall_pct = 24;
    send_random_lines(PHASE_LINES);

    // Long result-side hold while lines keep coming, so the input stalls:
    // the first line fills the result queue, the second fills the line
    // queue, and the third waits at its first character.
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_req      = 1'b1;
    send_text("OPENSONG abcd");
    send_text("PLAY");
    send_text("STOP");
    hold_req      = 1'b0;
    push <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Run covered %0d lines in %0d input words; %0d result words checked.",
             lines_sent, words_sent, checked);
    $display("Lines accepted: %0d, lines rejected as malformed: %0d.",
             accepted_lines, rejected_lines);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
